// ===== src/sem_pkg.sv =====
// shared types, constants and helpers of the sobel edge magnitude block
`default_nettype none
package sem_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int CFG_W      = 13;
	localparam int GRAD_W     = 11;
	localparam int NSQ_W      = 21;
	localparam int ROOT_W     = 11;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] edge_red;
		logic [7:0] edge_green;
		logic [7:0] edge_blue;
		logic       frame_end;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_SQR,
		S_ROOT,
		S_DONE
	} state_t;

	typedef logic [2:0][2:0][7:0] win3_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
	} grad_t;

	// sobel sums over one channel, p[row][col]
	function automatic grad_t sem_grad(input win3_t p);
		grad_t g;
		logic signed [GRAD_W-1:0] pos_x, neg_x, pos_y, neg_y;
		pos_x = GRAD_W'(p[0][2]) + (GRAD_W'(p[1][2]) <<< 1) + GRAD_W'(p[2][2]);
		neg_x = GRAD_W'(p[0][0]) + (GRAD_W'(p[1][0]) <<< 1) + GRAD_W'(p[2][0]);
		pos_y = GRAD_W'(p[2][0]) + (GRAD_W'(p[2][1]) <<< 1) + GRAD_W'(p[2][2]);
		neg_y = GRAD_W'(p[0][0]) + (GRAD_W'(p[0][1]) <<< 1) + GRAD_W'(p[0][2]);
		g.gx = pos_x - neg_x;
		g.gy = pos_y - neg_y;
		return g;
	endfunction
endpackage
`default_nettype wire

// ===== src/sem_if.sv =====
// valid/ready channel carrying one item of a given payload type
`default_nettype none
interface sem_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/sem_ram.sv =====
// generic single-port-write, single-port-read synchronous ram
`default_nettype none
module sem_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/sem_sqrt.sv =====
// bit-serial integer square root, rounded to nearest and saturated to 8 bits
`default_nettype none
module sem_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic signed [sem_pkg::GRAD_W-1:0] gx,
	input  wire logic signed [sem_pkg::GRAD_W-1:0] gy,
	output logic                             done,
	output logic [7:0]                       root
);
	import sem_pkg::*;

	logic [NSQ_W-1:0]  n_q;
	logic [ROOT_W-1:0] k_q;
	logic [3:0]        bit_q;
	logic              busy_q;
	logic              rnd_q;
	logic              done_q;
	logic [7:0]        root_q;

	logic [ROOT_W-1:0]   t;
	logic [2*ROOT_W-1:0] tt;
	logic [2*ROOT_W-1:0] kk;
	logic [ROOT_W:0]     kr;
	logic [2*GRAD_W-1:0] sx, sy;

	always_comb begin
		sx = (2*GRAD_W)'($signed(gx) * $signed(gx));
		sy = (2*GRAD_W)'($signed(gy) * $signed(gy));
		t  = k_q | (ROOT_W'(1) << bit_q);
		tt = (2*ROOT_W)'(t) * (2*ROOT_W)'(t);
		kk = (2*ROOT_W)'(k_q) * (2*ROOT_W)'(k_q) + (2*ROOT_W)'(k_q);
		kr = (ROOT_W+1)'(k_q) + (ROOT_W+1)'((2*ROOT_W)'(n_q) > kk);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= 1'b0;
			end else if (busy_q && rnd_q) begin
				busy_q <= 1'b0;
				rnd_q  <= 1'b0;
				done_q <= 1'b1;
			end else if (busy_q && bit_q == 4'd0) begin
				rnd_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= NSQ_W'(sx) + NSQ_W'(sy);
			k_q   <= '0;
			bit_q <= 4'(ROOT_W - 1);
		end else if (busy_q && !rnd_q) begin
			if (tt <= (2*ROOT_W)'(n_q)) begin
				k_q <= t;
			end
			if (bit_q != 4'd0) begin
				bit_q <= bit_q - 4'd1;
			end
		end else if (busy_q && rnd_q) begin
			root_q <= (kr > (ROOT_W+1)'(255)) ? 8'd255 : kr[7:0];
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== src/sobel_edge_magnitude_rgb.sv =====
// top level of the streaming rgb sobel edge magnitude block
`default_nettype none
// streaming 3x3 sobel edge magnitude on raster-order rgb pixels. each item
// (pixel or flush) that yields a result passes through these steps: take it
// and read the line store, shift the window and write the line store back,
// load the squared sums into the square roots, run the three bit-serial
// square roots, one per channel, in parallel (eleven bit steps, rounding,
// finish) and load the output register, which waits while the output
// register is full and not being taken; an item that yields no result takes
// only the first two steps. no new item is taken until the last one is
// through. results trail the input by one row and one pixel; after a frame's
// last pixel, width+1 flush items drive out the remaining results. neighbours
// outside the frame count as zero. a write to either frame register restarts
// the frame. the two line stores sit side by side in one 48-bit wide ram, read,
// then written back, one item at a time, so no two accesses ever overlap
module sobel_edge_magnitude_rgb (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	sem_if.sink                              pixels,
	sem_if.source                            edges,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [sem_pkg::CFG_W-1:0]   cfg_data
);
	import sem_pkg::*;

	state_t state_q, state_d;

	// frame geometry
	logic [FW_W-1:0]  width_q;
	logic [FH_W-1:0]  height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// current item
	logic [23:0] pix_q;
	logic        emit_q;
	logic        fe_q;

	// window, [row][col], col 2 newest
	logic [2:0][2:0][23:0] win_q;

	grad_t [2:0] grad_q;

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	// line store ram
	logic             mem_we;
	logic             mem_re;
	logic [47:0]      mem_rdata;
	logic [23:0]      a_old, b_new;

	logic             in_fire;
	logic             is_pixel;
	logic             flush_ok;
	logic             take;
	logic [COL_W-1:0] eff_col;
	logic [ROW_W-1:0] eff_row;

	logic             emit_col0, emit_main;
	logic [ROW_W-1:0] rb;
	logic [2:0]       rowv;
	logic             colv0;
	win3_t [2:0]      mat;
	grad_t [2:0]      grad_d;
	logic             fe_d;

	logic             root_start;
	logic [2:0]       root_done;
	logic [2:0][7:0]  root_val;
	logic             out_load;

	logic [FW_W-1:0]  cfg_w;
	logic [FH_W-1:0]  cfg_h;

	// row r of the window holds frame row rb-2+r; valid when inside the frame
	function automatic logic row_ok(input logic [ROW_W-1:0] b, input logic [1:0] r,
		input logic [FH_W-1:0] h);
		logic [ROW_W:0] s;
		s = (ROW_W+1)'(b) + (ROW_W+1)'(r);
		return (s >= (ROW_W+1)'(2)) && (s < (ROW_W+1)'(h) + (ROW_W+1)'(2));
	endfunction

	assign in_fire  = pixels.valid && pixels.ready;
	assign is_pixel = pixels.data.cmd == CMD_PIXEL;
	assign flush_ok = (row_q == ROW_W'(height_q)) ||
		((row_q == ROW_W'(height_q) + ROW_W'(1)) && col_q == '0);
	assign take     = is_pixel || flush_ok;

	// a pixel after the frame's end starts a new frame
	always_comb begin
		eff_col = col_q;
		eff_row = row_q;
		if (is_pixel && row_q >= ROW_W'(height_q)) begin
			eff_col = '0;
			eff_row = '0;
		end
	end

	assign mem_re = in_fire && take;
	assign {a_old, b_new} = mem_rdata;

	sem_ram #(
		.WIDTH(48),
		.DEPTH(MAX_WIDTH)
	) u_rows (
		.clk   (clk),
		.we    (mem_we),
		.waddr (col_q),
		.wdata ({b_new, pix_q}),
		.re    (mem_re),
		.raddr (eff_col),
		.rdata (mem_rdata)
	);

	// result selection and sobel sums
	always_comb begin
		emit_col0 = (col_q == '0) && (row_q >= ROW_W'(2));
		emit_main = (col_q != '0) && (row_q >= ROW_W'(1));
		// the column-zero case closes the previous row, one row further back
		rb        = emit_col0 ? row_q - ROW_W'(1) : row_q;
		colv0     = emit_col0 ? (width_q >= FW_W'(2)) : (col_q >= COL_W'(2));
		for (int r = 0; r < 3; r++) begin
			rowv[r] = row_ok(rb, 2'(r), height_q);
		end
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				mat[ch][r][0] = (rowv[r] && colv0) ? win_q[r][1][16-8*ch +: 8] : 8'd0;
				mat[ch][r][1] = rowv[r] ? win_q[r][2][16-8*ch +: 8] : 8'd0;
				mat[ch][r][2] = 8'd0;
			end
			if (emit_main) begin
				mat[ch][0][2] = rowv[0] ? a_old[16-8*ch +: 8] : 8'd0;
				mat[ch][1][2] = rowv[1] ? b_new[16-8*ch +: 8] : 8'd0;
				mat[ch][2][2] = rowv[2] ? pix_q[16-8*ch +: 8] : 8'd0;
			end
			grad_d[ch] = sem_grad(mat[ch]);
		end
		if (emit_col0) begin
			fe_d = (row_q == ROW_W'(height_q) + ROW_W'(1));
		end else begin
			// a row's last column only completes at the start of the next row
			fe_d = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && take) begin
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				state_d = (emit_col0 || emit_main) ? S_SQR : S_IDLE;
			end
			S_SQR: begin
				state_d = S_ROOT;
			end
			S_ROOT: begin
				if (root_done[0]) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || edges.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		pixels.ready = 1'b0;
		mem_we       = 1'b0;
		root_start   = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			S_IDLE: pixels.ready = 1'b1;
			S_MOD:  mem_we       = 1'b1;
			S_SQR:  root_start   = 1'b1;
			S_ROOT: ;
			S_DONE: out_load     = !out_valid_q || edges.ready;
			default: ;
		endcase
	end

	// saturated register values
	always_comb begin
		cfg_w = cfg_data[FW_W-1:0];
		if (cfg_w == '0) begin
			cfg_w = FW_W'(1);
		end else if (cfg_w > FW_W'(MAX_WIDTH)) begin
			cfg_w = FW_W'(MAX_WIDTH);
		end
		cfg_h = cfg_data[FH_W-1:0];
		if (cfg_h == '0) begin
			cfg_h = FH_W'(1);
		end else if (cfg_h > FH_W'(MAX_HEIGHT)) begin
			cfg_h = FH_W'(MAX_HEIGHT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= FW_W'(1024);
			height_q    <= FH_W'(768);
			col_q       <= '0;
			row_q       <= '0;
			win_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
				if (cfg_index == REG_FRAME_WIDTH) begin
					width_q <= cfg_w;
				end else begin
					height_q <= cfg_h;
				end
				col_q <= '0;
				row_q <= '0;
			end else if (in_fire && take) begin
				col_q <= eff_col;
				row_q <= eff_row;
			end else if (state_q == S_MOD) begin
				if ((FW_W'(col_q) + FW_W'(1)) >= width_q) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (state_q == S_MOD) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= a_old;
				win_q[1][2] <= b_new;
				win_q[2][2] <= pix_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (edges.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && take) begin
			// a flush acts as a zero pixel
			pix_q <= is_pixel ? {pixels.data.pixel_red, pixels.data.pixel_green,
				pixels.data.pixel_blue} : 24'd0;
		end
		if (state_q == S_MOD) begin
			grad_q <= grad_d;
			fe_q   <= fe_d;
			emit_q <= emit_col0 || emit_main;
		end
		if (out_load) begin
			out_q.edge_red   <= root_val[0];
			out_q.edge_green <= root_val[1];
			out_q.edge_blue  <= root_val[2];
			out_q.frame_end  <= fe_q;
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_root
		sem_sqrt u_sqrt (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (root_start),
			.gx     (grad_q[ch].gx),
			.gy     (grad_q[ch].gy),
			.done   (root_done[ch]),
			.root   (root_val[ch])
		);
	end

	assign edges.valid = out_valid_q;
	assign edges.data  = out_q;

	// checks
	a_rose_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared without a finished item");

	a_sqr_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQR |-> emit_q)
		else $error("root started for an item without result");

	a_roots_agree: assert property (@(posedge clk) disable iff (!arst_n)
		root_done[0] |-> (root_done[1] && root_done[2] && state_q == S_ROOT))
		else $error("channel roots out of step");

	a_ram_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> $past(mem_re))
		else $error("line store written without a preceding read");
endmodule
`default_nettype wire

// ===== sim/sobel_edge_magnitude_rgb_tb.sv =====
// self-checking testbench for the streaming rgb sobel edge magnitude block
`default_nettype none
module sobel_edge_magnitude_rgb_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sem_pkg::*;

	localparam int DRAIN_CYCLES = 40;	// wait that lets a no-result item still in flight finish
	localparam int HOLD_CYCLES  = 400;	// long receiver hold-off to back up the pipeline

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_ITEM
	} row_kind_t;

	// one line of the directed stimulus table
	typedef struct {
		row_kind_t   kind;
		logic [1:0]  index;
		int unsigned value;
		in_item_t    item;
		bit          typed;
		out_item_t   typed_edge;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	sem_if #(.T(in_item_t))  pixels();
	sem_if #(.T(out_item_t)) edges();

	sobel_edge_magnitude_rgb dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pixels),
		.edges(edges),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// shadow copy of the block: line stores, window, positions, frame size
	// ---------------------------------------------------------------
	logic [23:0] shadow_older [MAX_WIDTH];
	logic [23:0] shadow_newer [MAX_WIDTH];
	logic [23:0] shadow_win [3][3];
	int unsigned shadow_col, shadow_row;
	int unsigned shadow_fw = 1024;
	int unsigned shadow_fh = 768;

	out_item_t pending_edges[$];	// expected results, oldest first
	int errors = 0;
	bit hold_req = 0;	// sender asks the receiver for one long hold-off
	bit calm = 0;	// no random gaps or stalls start on either side while set

	// rounded square root, saturated to a byte
	function automatic logic [7:0] edge_mag(int gx, int gy);
		int unsigned n, k, t;
		n = gx * gx + gy * gy;
		k = 0;
		for (int b = 11; b >= 0; b--) begin
			t = k | (1 << b);
			if (t * t <= n)
				k = t;
		end
		if (n > k * k + k)
			k++;
		return (k > 255) ? 8'd255 : k[7:0];
	endfunction

	function automatic bit in_frame(int r);
		return r >= 0 && r < int'(shadow_fh);
	endfunction

	// one result from window columns off..off+2; rv/cv mask rows and columns outside the frame
	function automatic out_item_t window_edges(int off, bit rv[3], bit cv[3],
			int unsigned orow, int unsigned ocol);
		out_item_t res;
		int gx, gy, v;
		logic [7:0] mag;
		for (int ch = 0; ch < 3; ch++) begin
			gx = 0;
			gy = 0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) begin
					if (!rv[r] || !cv[c])
						continue;
					v = (shadow_win[r][off + c] >> (16 - 8 * ch)) & 8'hff;
					// sobel kernels: x weights by column, y weights by row
					gx += (c - 1) * ((r == 1) ? 2 : 1) * v;
					gy += (r - 1) * ((c == 1) ? 2 : 1) * v;
				end
			mag = edge_mag(gx, gy);
			case (ch)
				0: res.edge_red = mag;
				1: res.edge_green = mag;
				default: res.edge_blue = mag;
			endcase
		end
		res.frame_end = (orow + 1 == shadow_fh) && (ocol + 1 == shadow_fw);
		return res;
	endfunction

	// push one pixel (real or zero) through the shadow line stores and window
	function automatic void shift_pixel(logic [23:0] pix, output bit got, output out_item_t res);
		int ir, ic, idx;
		bit rv[3], cv[3];
		logic [23:0] a, b;
		ir = shadow_row;
		ic = shadow_col;
		idx = (ic < MAX_WIDTH) ? ic : 0;
		got = 0;
		// start of a row: last column of the row two above completes
		if (ic == 0 && ir >= 2) begin
			rv = '{in_frame(ir - 3), in_frame(ir - 2), in_frame(ir - 1)};
			cv = '{shadow_fw >= 2, 1'b1, 1'b0};
			res = window_edges(1, rv, cv, ir - 2, shadow_fw - 1);
			got = 1;
		end
		a = shadow_older[idx];
		b = shadow_newer[idx];
		shadow_older[idx] = b;
		shadow_newer[idx] = pix;
		for (int r = 0; r < 3; r++) begin
			shadow_win[r][0] = shadow_win[r][1];
			shadow_win[r][1] = shadow_win[r][2];
		end
		shadow_win[0][2] = a;
		shadow_win[1][2] = b;
		shadow_win[2][2] = pix;
		if (ic >= 1 && ir >= 1) begin
			rv = '{in_frame(ir - 2), in_frame(ir - 1), in_frame(ir)};
			cv = '{ic >= 2, 1'b1, 1'b1};
			res = window_edges(0, rv, cv, ir - 1, ic - 1);
			got = 1;
		end
		ic++;
		if (ic >= shadow_fw) begin
			ic = 0;
			shadow_row++;
		end
		shadow_col = ic;
	endfunction

	function automatic void predict_edges(in_item_t it, output bit got, output out_item_t res);
		got = 0;
		if (it.cmd == CMD_PIXEL) begin
			// pixel after the frame's end opens a new frame
			if (shadow_row >= shadow_fh) begin
				shadow_row = 0;
				shadow_col = 0;
			end
			shift_pixel({it.pixel_red, it.pixel_green, it.pixel_blue}, got, res);
		end else if (shadow_row == shadow_fh || (shadow_row == shadow_fh + 1 && shadow_col == 0))
			shift_pixel(24'd0, got, res);
		// other flushes do nothing
	endfunction

	function automatic void predict_config(logic [1:0] index, int unsigned value);
		int unsigned v;
		if (index == REG_FRAME_WIDTH) begin
			v = value & 32'h7ff;
			shadow_fw = (v < 1) ? 1 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
		end else if (index == REG_FRAME_HEIGHT) begin
			v = value & 32'h1fff;
			shadow_fh = (v < 1) ? 1 : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
		end else
			return;	// unused index
		shadow_col = 0;
		shadow_row = 0;
	endfunction

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------
	function automatic int sender_gap();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 70)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);	// the odd long gap
	endfunction

	// offer one item, wait for it to be taken, then record what it should yield
	task automatic send_item(in_item_t it, bit typed = 0, out_item_t typed_edge = '0);
		int gap;
		bit got;
		out_item_t res;
		gap = sender_gap();
		if (gap > 0) begin
			pixels.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixels.valid <= 1'b1;
		pixels.data <= it;
		do @(posedge clk); while (!pixels.ready);
		predict_edges(it, got, res);
		if (got)
			pending_edges.push_back(typed ? typed_edge : res);
	endtask

	// registers change only once the block has gone quiet
	task automatic write_reg(logic [1:0] index, int unsigned value);
		pixels.valid <= 1'b0;
		while (pending_edges.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		predict_config(index, value);
	endtask

	function automatic in_item_t pixel_item(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		return '{cmd: CMD_PIXEL, pixel_red: r, pixel_green: g, pixel_blue: b};
	endfunction

	function automatic in_item_t flush_item();
		return '{cmd: CMD_FLUSH, pixel_red: 8'($urandom), pixel_green: 8'($urandom),
			pixel_blue: 8'($urandom)};
	endfunction

	function automatic stim_row_t cfg_row(logic [1:0] index, int unsigned value);
		return '{kind: ROW_CFG, index: index, value: value, item: '0, typed: 0,
			typed_edge: '0};
	endfunction

	function automatic stim_row_t item_row(in_item_t it, bit typed = 0,
			out_item_t typed_edge = '0);
		return '{kind: ROW_ITEM, index: '0, value: 0, item: it, typed: typed,
			typed_edge: typed_edge};
	endfunction

	// mostly random bytes, with the extremes now and then
	function automatic logic [7:0] rand_byte();
		int p;
		p = $urandom_range(0, 9);
		return (p == 0) ? 8'h00 : (p == 1) ? 8'hff : 8'($urandom);
	endfunction

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin
		stim_row_t plan[$];
		int unsigned fw, fh, n_pixels, n_flush;
		int sent;
		pixels.valid <= 1'b0;
		pixels.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: saturating writes, a 1x1 frame, a 3x2 frame with stray flushes
		plan.push_back(cfg_row(REG_FRAME_WIDTH, 0));	// below range, becomes 1
		plan.push_back(cfg_row(REG_FRAME_HEIGHT, 0));
		plan.push_back(item_row(pixel_item(8'hff, 8'h00, 8'h80)));
		plan.push_back(item_row(flush_item()));
		// single pixel frame: centre tap weighs nothing, so zero magnitude and frame end
		plan.push_back(item_row(flush_item(), 1,
			'{edge_red: 8'd0, edge_green: 8'd0, edge_blue: 8'd0, frame_end: 1'b1}));
		plan.push_back(item_row(flush_item()));	// after draining: ignored
		plan.push_back(cfg_row(2'd2, 5));	// unused index
		plan.push_back(cfg_row(2'd3, 8191));
		plan.push_back(cfg_row(REG_FRAME_WIDTH, 3));
		plan.push_back(cfg_row(REG_FRAME_HEIGHT, 2));
		plan.push_back(item_row(pixel_item(8'hff, 8'hff, 8'hff)));
		plan.push_back(item_row(pixel_item(8'h00, 8'h00, 8'h00)));
		plan.push_back(item_row(flush_item()));	// mid-frame flush: ignored
		plan.push_back(item_row(pixel_item(8'hff, 8'h00, 8'hff)));
		plan.push_back(item_row(pixel_item(8'h00, 8'hff, 8'h00)));
		plan.push_back(item_row(pixel_item(8'hff, 8'hff, 8'hff)));
		plan.push_back(item_row(pixel_item(8'h01, 8'hfe, 8'h7f)));
		plan.push_back(item_row(flush_item()));
		// new frame while results are still pending: the rest are dropped
		plan.push_back(item_row(pixel_item(8'h80, 8'h40, 8'h20)));
		plan.push_back(cfg_row(REG_FRAME_WIDTH, 2047));	// above range, becomes max
		plan.push_back(cfg_row(REG_FRAME_HEIGHT, 8191));

		foreach (plan[i])
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].index, plan[i].value);
			else
				send_item(plan[i].item, plan[i].typed, plan[i].typed_edge);

		// widest row with a short drain, a single-column frame, then random frames
		write_reg(REG_FRAME_WIDTH, MAX_WIDTH);
		write_reg(REG_FRAME_HEIGHT, 1);
		calm = 1;
		repeat (MAX_WIDTH) send_item(pixel_item(rand_byte(), rand_byte(), rand_byte()));
		repeat (16) send_item(flush_item());
		calm = 0;
		write_reg(REG_FRAME_WIDTH, 1);
		write_reg(REG_FRAME_HEIGHT, 48);
		repeat (48) send_item(pixel_item(rand_byte(), rand_byte(), rand_byte()));
		repeat (2) send_item(flush_item());

		sent = 0;
		fw = 4;
		fh = 4;
		while (sent < 560) begin
			// reshape the frame most of the time; otherwise start straight into a new one
			if ($urandom_range(0, 3) != 0) begin
				fw = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				fh = $urandom_range(1, 8);
				write_reg(REG_FRAME_WIDTH, fw);
				write_reg(REG_FRAME_HEIGHT, fh);
			end
			calm = ($urandom_range(0, 5) == 0);
			n_pixels = fw * fh;
			if (n_pixels >= 8 && !hold_req && sent > 50 && sent < 400)
				hold_req = 1;
			for (int p = 0; p < n_pixels; p++) begin
				if ($urandom_range(0, 19) == 0)
					send_item(flush_item());	// noise, ignored mid-frame
				send_item(pixel_item(rand_byte(), rand_byte(), rand_byte()));
				sent++;
			end
			// usually a full drain with a spare flush or two, sometimes cut short
			n_flush = ($urandom_range(0, 6) == 0) ? $urandom_range(0, fw)
				: fw + 1 + $urandom_range(0, 2);
			repeat (n_flush) send_item(flush_item());
		end
		pixels.valid <= 1'b0;

		while (pending_edges.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// ---------------------------------------------------------------
	// receiver side: random ready, one long hold-off on request
	// ---------------------------------------------------------------
	initial begin
		int stall;
		out_item_t want;
		edges.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && edges.ready) begin
				edges.ready <= 1'b0;
				hold_req = 0;
				stall = HOLD_CYCLES;
			end else if (stall > 0) begin
				edges.ready <= 1'b0;
				stall--;
			end else if (calm)
				edges.ready <= 1'b1;
			else if ($urandom_range(0, 99) < 2)
				stall = $urandom_range(15, 60);
			else
				edges.ready <= ($urandom_range(0, 9) < 7);
			@(posedge clk);
			if (edges.valid && edges.ready) begin
				if (pending_edges.size() == 0) begin
					$error("result with nothing expected: %p", edges.data);
					errors++;
				end else begin
					want = pending_edges.pop_front();
					if (edges.data.edge_red !== want.edge_red) begin
						$error("edge_red: expected %0d, got %0d", want.edge_red,
							edges.data.edge_red);
						errors++;
					end
					if (edges.data.edge_green !== want.edge_green) begin
						$error("edge_green: expected %0d, got %0d", want.edge_green,
							edges.data.edge_green);
						errors++;
					end
					if (edges.data.edge_blue !== want.edge_blue) begin
						$error("edge_blue: expected %0d, got %0d", want.edge_blue,
							edges.data.edge_blue);
						errors++;
					end
					if (edges.data.frame_end !== want.frame_end) begin
						$error("frame_end: expected %0d, got %0d", want.frame_end,
							edges.data.frame_end);
						errors++;
					end
				end
			end
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#40ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/sem_pkg.sv
src/sem_if.sv
src/sem_ram.sv
src/sem_sqrt.sv
src/sobel_edge_magnitude_rgb.sv
sim/sobel_edge_magnitude_rgb_tb.sv
